FILE: rtl/core/itf_pkg.sv
`default_nettype none

package itf_pkg;

  localparam int MAX_CHARS  = 32;
  localparam int IDX_W      = $clog2(MAX_CHARS);
  localparam int POS_W      = $clog2(MAX_CHARS + 1);
  localparam int CMP_W      = (POS_W > 6) ? POS_W : 6;
  localparam int VAL_W      = 64;
  localparam int DEC_DIGITS = 20;
  localparam int BCD_W      = 4 * DEC_DIGITS;
  localparam int CNT_W      = $clog2(VAL_W);

  localparam logic [1:0] RADIX_OCT = 2'd0;
  localparam logic [1:0] RADIX_DEC = 2'd1;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ALPHA = 8'h57;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DABBLE,
    ST_DIGIT,
    ST_PAD,
    ST_PREFIX,
    ST_HEX_ZERO,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             is_signed;
    logic [1:0]       radix_select;
    logic [5:0]       pad_target;
    logic             alternate_form;
  } in_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last_char;
  } out_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [7:0]       data;
  } wr_t;

  function automatic logic [7:0] glyph(input logic [3:0] d);
    logic [7:0] res;
    if (d < 4'd10) begin
      res = CH_ZERO + {4'b0, d};
    end else begin
      res = CH_ALPHA + {4'b0, d};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/itf_text_ram.sv
`default_nettype none

module itf_text_ram (
  input  wire logic                     clk,
  input  wire itf_pkg::wr_t             wr,
  input  wire logic                     rd_en,
  input  wire logic [itf_pkg::IDX_W-1:0] rd_addr,
  output logic [7:0]                    rd_data
);

  logic [7:0] text_mem [itf_pkg::MAX_CHARS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      text_mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= text_mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/integer_to_text_formatter.sv
`default_nettype none

// Channel   Direction  Handshake                Payload
// input     in         start, busy              in_data  (itf_pkg::in_t)
// result    out        out_valid (strobe only)  out_data (itf_pkg::out_t)
//
// A transaction is taken when start is high and busy is low.
// After the accepting edge: 64 double-dabble steps for decimal (none for octal or hex),
// then one write per digit and per pad character, one pad check, any prefix writes, and
// one read per emitted character; each character appears in the cycle after its read.
// Decimal conversion uses a bit-serial binary-to-BCD shift register (double dabble).
// Characters leave on consecutive cycles, one per cycle, and cannot be stalled.
// Reset is synchronous, active low, and returns the block to idle at the next edge.

module integer_to_text_formatter (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire itf_pkg::in_t  in_data,
  output logic               out_valid,
  output itf_pkg::out_t      out_data
);

  itf_pkg::state_t state_r, state_nxt;

  logic [itf_pkg::VAL_W-1:0] mag_r, mag_nxt;
  logic [itf_pkg::BCD_W-1:0] dig_r, dig_nxt;
  logic [itf_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [itf_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [5:0]                pad_r, pad_nxt;
  logic                      alt_r, alt_nxt;
  logic                      oct_r, oct_nxt;
  logic                      dec_r, dec_nxt;
  logic                      zero_r, zero_nxt;
  logic [itf_pkg::IDX_W-1:0] rd_r, rd_nxt;
  logic                      valid_r;
  logic                      last_r;

  logic                      accept;
  logic                      neg;
  logic [itf_pkg::VAL_W-1:0] in_mag;
  logic [itf_pkg::BCD_W-1:0] dig_adj;
  logic [3:0]                digit;
  logic                      rest_nz;
  logic [itf_pkg::POS_W-1:0] len;
  logic                      pad_more;
  logic                      emit_last;
  logic                      rd_en;
  logic [itf_pkg::POS_W-1:0] pos_dec;
  logic [itf_pkg::POS_W-1:0] pos_hex;
  logic [itf_pkg::POS_W-1:0] pos_oct;
  itf_pkg::wr_t              wr;
  logic [7:0]                rd_data;

  assign accept   = start && (state_r == itf_pkg::ST_IDLE);
  assign busy     = (state_r != itf_pkg::ST_IDLE);
  assign neg      = in_data.is_signed && in_data.value[itf_pkg::VAL_W-1];
  assign in_mag   = neg ? (~in_data.value + 1'b1) : in_data.value;
  assign digit    = oct_r ? {1'b0, dig_r[2:0]} : dig_r[3:0];
  assign rest_nz  = oct_r ? (|dig_r[itf_pkg::BCD_W-1:3]) : (|dig_r[itf_pkg::BCD_W-1:4]);
  assign len      = itf_pkg::POS_W'(itf_pkg::MAX_CHARS) - pos_r;
  assign pad_more = (pos_r != '0) && (itf_pkg::CMP_W'(len) < itf_pkg::CMP_W'(pad_r));
  assign emit_last = (rd_r == itf_pkg::IDX_W'(itf_pkg::MAX_CHARS - 1));
  assign rd_en    = (state_r == itf_pkg::ST_EMIT);
  assign pos_dec  = pos_r - 1'b1;
  assign pos_hex  = (pos_r < itf_pkg::POS_W'(2)) ? itf_pkg::POS_W'(1) : pos_dec;
  assign pos_oct  = (pos_r == '0) ? '0 : pos_dec;

  always_comb begin
    dig_adj = dig_r;
    for (int i = 0; i < itf_pkg::DEC_DIGITS; i++) begin
      if (dig_r[4*i +: 4] >= 4'd5) begin
        dig_adj[4*i +: 4] = dig_r[4*i +: 4] + 4'd3;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      itf_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_data.radix_select == itf_pkg::RADIX_DEC) ?
                      itf_pkg::ST_DABBLE : itf_pkg::ST_DIGIT;
        end
      end
      itf_pkg::ST_DABBLE: begin
        if (cnt_r == '0) begin
          state_nxt = itf_pkg::ST_DIGIT;
        end
      end
      itf_pkg::ST_DIGIT: begin
        if (!(rest_nz && (pos_dec != '0))) begin
          state_nxt = itf_pkg::ST_PAD;
        end
      end
      itf_pkg::ST_PAD: begin
        if (!pad_more) begin
          state_nxt = alt_r ? itf_pkg::ST_PREFIX : itf_pkg::ST_EMIT;
        end
      end
      itf_pkg::ST_PREFIX: begin
        state_nxt = (!oct_r && !dec_r) ? itf_pkg::ST_HEX_ZERO : itf_pkg::ST_EMIT;
      end
      itf_pkg::ST_HEX_ZERO: begin
        state_nxt = itf_pkg::ST_EMIT;
      end
      itf_pkg::ST_EMIT: begin
        if (emit_last) begin
          state_nxt = itf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = itf_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    mag_nxt  = mag_r;
    dig_nxt  = dig_r;
    cnt_nxt  = cnt_r;
    pos_nxt  = pos_r;
    pad_nxt  = pad_r;
    alt_nxt  = alt_r;
    oct_nxt  = oct_r;
    dec_nxt  = dec_r;
    zero_nxt = zero_r;
    wr       = '0;
    case (state_r)
      itf_pkg::ST_IDLE: begin
        if (accept) begin
          mag_nxt = in_mag;
          dig_nxt = (in_data.radix_select == itf_pkg::RADIX_DEC) ?
                    '0 : itf_pkg::BCD_W'(in_mag);
          cnt_nxt = itf_pkg::CNT_W'(itf_pkg::VAL_W - 1);
          pos_nxt = itf_pkg::POS_W'(itf_pkg::MAX_CHARS);
          pad_nxt = in_data.pad_target;
          alt_nxt = in_data.alternate_form || neg;
          oct_nxt = (in_data.radix_select == itf_pkg::RADIX_OCT);
          dec_nxt = (in_data.radix_select == itf_pkg::RADIX_DEC);
        end
      end
      itf_pkg::ST_DABBLE: begin
        dig_nxt = {dig_adj[itf_pkg::BCD_W-2:0], mag_r[itf_pkg::VAL_W-1]};
        mag_nxt = {mag_r[itf_pkg::VAL_W-2:0], 1'b0};
        cnt_nxt = cnt_r - 1'b1;
      end
      itf_pkg::ST_DIGIT: begin
        wr.en    = 1'b1;
        wr.addr  = pos_dec[itf_pkg::IDX_W-1:0];
        wr.data  = itf_pkg::glyph(digit);
        zero_nxt = (digit == 4'd0);
        pos_nxt  = pos_dec;
        dig_nxt  = oct_r ? (dig_r >> 3) : (dig_r >> 4);
      end
      itf_pkg::ST_PAD: begin
        if (pad_more) begin
          wr.en    = 1'b1;
          wr.addr  = pos_dec[itf_pkg::IDX_W-1:0];
          wr.data  = itf_pkg::CH_ZERO;
          zero_nxt = 1'b1;
          pos_nxt  = pos_dec;
        end
      end
      itf_pkg::ST_PREFIX: begin
        if (dec_r) begin
          wr.en   = 1'b1;
          wr.addr = pos_oct[itf_pkg::IDX_W-1:0];
          wr.data = itf_pkg::CH_MINUS;
          pos_nxt = pos_oct;
        end else if (oct_r) begin
          if (!zero_r) begin
            wr.en   = 1'b1;
            wr.addr = pos_oct[itf_pkg::IDX_W-1:0];
            wr.data = itf_pkg::CH_ZERO;
            pos_nxt = pos_oct;
          end
        end else begin
          wr.en   = 1'b1;
          wr.addr = pos_hex[itf_pkg::IDX_W-1:0];
          wr.data = itf_pkg::CH_X;
          pos_nxt = pos_hex;
        end
      end
      itf_pkg::ST_HEX_ZERO: begin
        wr.en   = 1'b1;
        wr.addr = pos_dec[itf_pkg::IDX_W-1:0];
        wr.data = itf_pkg::CH_ZERO;
        pos_nxt = pos_dec;
      end
      default: begin
        wr = '0;
      end
    endcase
    rd_nxt = rd_en ? (rd_r + 1'b1) : pos_nxt[itf_pkg::IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= itf_pkg::ST_IDLE;
      valid_r <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= rd_en;
      last_r  <= rd_en && emit_last;
    end
  end

  always_ff @(posedge clk) begin
    mag_r  <= mag_nxt;
    dig_r  <= dig_nxt;
    cnt_r  <= cnt_nxt;
    pos_r  <= pos_nxt;
    pad_r  <= pad_nxt;
    alt_r  <= alt_nxt;
    oct_r  <= oct_nxt;
    dec_r  <= dec_nxt;
    zero_r <= zero_nxt;
    rd_r   <= rd_nxt;
  end

  itf_text_ram u_text_ram (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (rd_en),
    .rd_addr (rd_r),
    .rd_data (rd_data)
  );

  assign out_valid          = valid_r;
  assign out_data.character = rd_data;
  assign out_data.last_char = last_r;

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("block not busy after an accepted transaction");

  a_emit_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_char |=> out_valid)
    else $error("gap inside an emitted text");

  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last_char |=> !out_valid)
    else $error("character emitted after the last one");

  a_idle_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    !busy && out_valid |-> out_data.last_char)
    else $error("block went idle before the last character");
`endif

endmodule

`default_nettype wire
